/* hdl/rgb_to_ascii_glyph_stream_assert.svh */
// assertion macros shared by the glyph stream modules
`ifndef RGB_TO_ASCII_GLYPH_STREAM_ASSERT_SVH
`define RGB_TO_ASCII_GLYPH_STREAM_ASSERT_SVH

// same-cycle implication, checked outside reset
`define R2A_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define R2A_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/r2a_pkg.sv */
// shared types and constants of the rgb to glyph stream block
package r2a_pkg;

  // field widths
  localparam int CHAN_W  = 8;
  localparam int PIXEL_W = 3 * CHAN_W;
  localparam int CHAR_W  = 8;
  localparam int LEVEL_W = 3;
  localparam int LUMA_W  = 24;

  // configuration port
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 32;
  localparam int ROW_WIDTH_W = 13;
  localparam int COL_W       = 12;

  localparam logic [CFG_INDEX_W-1:0] REG_ROW_WIDTH   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_GLYPHS_LOW  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_GLYPHS_HIGH = 2'd2;

  // register reset values
  localparam logic [ROW_WIDTH_W-1:0] ROW_WIDTH_RST   = 13'd80;
  localparam logic [CFG_DATA_W-1:0]  GLYPHS_LOW_RST  = 32'h2D3A2E20;
  localparam logic [CFG_DATA_W-1:0]  GLYPHS_HIGH_RST = 32'h23402B3D;

  // widest row; wider settings saturate here
  localparam logic [ROW_WIDTH_W-1:0] MAX_ROW_WIDTH = 13'd4096;

  // bt.601 luma weights in q16
  localparam logic [LUMA_W-1:0] COEF_R = 24'd19595;
  localparam logic [LUMA_W-1:0] COEF_G = 24'd38470;
  localparam logic [LUMA_W-1:0] COEF_B = 24'd7471;

  localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;

  // queue between classifier and emitter
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCOUNT_W    = $clog2(QUEUE_DEPTH + 1);

  // one classified pixel
  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic               row_close;
  } entry_t;

  // a classified pixel together with its valid flag
  typedef struct packed {
    logic   valid;
    entry_t entry;
  } entry_req_t;

endpackage

/* hdl/r2a_front.sv */
// front end: accepts pixels, forms the glyph level and tracks row position
module r2a_front (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [r2a_pkg::PIXEL_W-1:0]         s_tdata,   // red, green, blue
  input  logic [r2a_pkg::ROW_WIDTH_W-1:0]     row_width,
  input  logic                                queue_full,
  output r2a_pkg::entry_req_t                 push
);
  import r2a_pkg::*;

  logic [COL_W-1:0]       column_count;
  logic [COL_W-1:0]       column_count_next;
  logic [ROW_WIDTH_W-1:0] width_eff;
  logic [ROW_WIDTH_W-1:0] col_plus;
  logic [LUMA_W-1:0]      luma_sum;
  logic                   accept;
  logic                   close;

  assign s_tready = !queue_full;
  assign accept   = s_tvalid && s_tready;

  // weighted channel sum; luma is bits 23:16
  assign luma_sum = COEF_R * LUMA_W'(s_tdata[CHAN_W-1:0])
                  + COEF_G * LUMA_W'(s_tdata[2*CHAN_W-1:CHAN_W])
                  + COEF_B * LUMA_W'(s_tdata[3*CHAN_W-1:2*CHAN_W]);

  // zero width acts as one, oversize saturates
  always_comb begin
    priority if (row_width > MAX_ROW_WIDTH) begin
      width_eff = MAX_ROW_WIDTH;
    end else if (row_width == '0) begin
      width_eff = ROW_WIDTH_W'(1);
    end else begin
      width_eff = row_width;
    end
  end

  // row closes once the count reaches or passes the width
  assign col_plus          = ROW_WIDTH_W'(column_count) + ROW_WIDTH_W'(1);
  assign close             = col_plus >= width_eff;
  assign column_count_next = close ? '0 : col_plus[COL_W-1:0];

  // min(luma*8/255, 7) equals the top three bits of luma
  assign push.valid           = accept;
  assign push.entry.level     = luma_sum[LUMA_W-1 -: LEVEL_W];
  assign push.entry.row_close = close;

  // column counter
  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
    end else if (accept) begin
      column_count <= column_count_next;
    end
  end

endmodule

/* hdl/r2a_queue.sv */
// short queue of classified pixels between front and back
`include "rgb_to_ascii_glyph_stream_assert.svh"

module r2a_queue (
  input  logic                clk,
  input  logic                rst,
  input  r2a_pkg::entry_req_t push,
  output logic                full,
  input  logic                pop,
  output r2a_pkg::entry_req_t head
);
  import r2a_pkg::*;

  entry_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCOUNT_W-1:0] count;

  assign full       = count == QCOUNT_W'(QUEUE_DEPTH);
  assign head.valid = count != '0;
  assign head.entry = slots[rd_ptr];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push.valid) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      unique case ({push.valid, pop})
        2'b10:   count <= count + QCOUNT_W'(1);
        2'b01:   count <= count - QCOUNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push.valid) begin
      slots[wr_ptr] <= push.entry;
    end
  end

  `R2A_ASSERT_IMP(q_no_overflow, clk, rst, push.valid, !full,
    "request pushed into a full queue")
  `R2A_ASSERT_IMP(q_no_underflow, clk, rst, pop, head.valid,
    "request popped from an empty queue")
  `R2A_ASSERT_NXT(q_count_step, clk, rst, push.valid && !pop,
    count == QCOUNT_W'($past(count) + 1'b1), "queue count lost a push")

endmodule

/* hdl/r2a_back.sv */
// back end: looks up glyphs and emits them, with a newline after each row
`include "rgb_to_ascii_glyph_stream_assert.svh"

module r2a_back (
  input  logic                           clk,
  input  logic                           rst,
  input  r2a_pkg::entry_req_t            head,
  output logic                           pop,
  input  logic [r2a_pkg::CFG_DATA_W-1:0] glyphs_low,
  input  logic [r2a_pkg::CFG_DATA_W-1:0] glyphs_high,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [r2a_pkg::CHAR_W-1:0]     m_tdata,   // char_code
  output logic                           m_tlast    // row_end
);
  import r2a_pkg::*;

  logic                  newline_owed;
  logic                  load;
  logic [CFG_DATA_W-1:0] glyph_word;
  logic [CHAR_W-1:0]     glyph;
  logic [CHAR_W-1:0]     char_code;
  logic                  row_end;

  // output register takes a new result when empty or being drained
  assign load = !m_tvalid || m_tready;
  assign pop  = load && !newline_owed && head.valid;

  // palette lookup
  assign glyph_word = head.entry.level[LEVEL_W-1] ? glyphs_high : glyphs_low;
  always_comb begin
    unique case (head.entry.level[1:0])
      2'd0: glyph = glyph_word[7:0];
      2'd1: glyph = glyph_word[15:8];
      2'd2: glyph = glyph_word[23:16];
      2'd3: glyph = glyph_word[31:24];
      default: glyph = glyph_word[7:0];
    endcase
  end

  // output valid and owed newline
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid     <= 1'b0;
      newline_owed <= 1'b0;
    end else if (load) begin
      if (newline_owed) begin
        m_tvalid     <= 1'b1;
        newline_owed <= 1'b0;
      end else if (head.valid) begin
        m_tvalid     <= 1'b1;
        newline_owed <= head.entry.row_close;
      end else begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (load) begin
      if (newline_owed) begin
        char_code <= NEWLINE_CODE;
        row_end   <= 1'b1;
      end else begin
        char_code <= glyph;
        row_end   <= 1'b0;
      end
    end
  end

  assign m_tdata = char_code;
  assign m_tlast = row_end;

  `R2A_ASSERT_NXT(b_newline_follows, clk, rst, load && newline_owed,
    m_tvalid && m_tlast && (m_tdata == NEWLINE_CODE), "owed newline not emitted")
  `R2A_ASSERT_NXT(b_close_owes_newline, clk, rst, pop && head.entry.row_close,
    m_tvalid && !m_tlast && newline_owed, "row close did not queue a newline")
  `R2A_ASSERT_IMP(b_last_is_newline, clk, rst, m_tvalid && m_tlast,
    m_tdata == NEWLINE_CODE, "row end without newline code")

endmodule

/* hdl/rgb_to_ascii_glyph_stream.sv */
// top level: rgb pixel stream to ascii glyph stream
//
//  channel   direction  signals                           request
//  s_*       in         tvalid tready tdata[23:0]         pixel: red, green, blue
//  m_*       out        tvalid tready tdata[7:0] tlast    char_code, row_end
//  cfg_*     in         wr_en index[1:0] wr_data[31:0]    register write
//
// one pixel a cycle is accepted while the queue is not full; its glyph passes
// through the queue into the output register; a row-closing pixel also emits a
// newline, an extra output item that the four-entry queue absorbs until it fills
// rst is synchronous: counters, queue and output valid clear, registers reload
// either side may stall independently; s_tready drops only when the queue is full
module rgb_to_ascii_glyph_stream (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [r2a_pkg::PIXEL_W-1:0]     s_tdata,     // red[7:0], green[15:8], blue[23:16]
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [r2a_pkg::CHAR_W-1:0]      m_tdata,     // char_code[7:0]
  output logic                            m_tlast,
  input  logic                            cfg_wr_en,
  input  logic [r2a_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [r2a_pkg::CFG_DATA_W-1:0]  cfg_wr_data
);
  import r2a_pkg::*;

  logic [ROW_WIDTH_W-1:0] row_width;
  logic [CFG_DATA_W-1:0]  glyphs_low;
  logic [CFG_DATA_W-1:0]  glyphs_high;
  entry_req_t             push;
  entry_req_t             head;
  logic                   queue_full;
  logic                   pop;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      row_width   <= ROW_WIDTH_RST;
      glyphs_low  <= GLYPHS_LOW_RST;
      glyphs_high <= GLYPHS_HIGH_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_ROW_WIDTH:   row_width   <= cfg_wr_data[ROW_WIDTH_W-1:0];
        REG_GLYPHS_LOW:  glyphs_low  <= cfg_wr_data;
        REG_GLYPHS_HIGH: glyphs_high <= cfg_wr_data;
        default: ;
      endcase
    end
  end

  // classifier
  r2a_front u_front (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .row_width  (row_width),
    .queue_full (queue_full),
    .push       (push)
  );

  // decoupling queue
  r2a_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .full (queue_full),
    .pop  (pop),
    .head (head)
  );

  // emitter
  r2a_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .pop         (pop),
    .glyphs_low  (glyphs_low),
    .glyphs_high (glyphs_high),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tlast     (m_tlast)
  );

endmodule
